// ===== rtl/core/efe_pkg.sv =====
package efe_pkg;

  localparam logic [7:0] EscByte   = 8'h5A;
  localparam logic [7:0] CodeEof   = 8'h00;
  localparam logic [7:0] CodeEofNc = 8'h01;
  localparam logic [7:0] CodeEsc   = 8'h02;
  localparam logic [7:0] CodeData  = 8'h80;
  localparam logic [7:0] CodeDebug = 8'h40;

  localparam int unsigned QueueDepthDefault = 4;

  // One classified payload byte, as handed from front to back.
  typedef struct packed {
    logic [7:0] payload;
    logic       first;
    logic       last;
    logic       debug_kind;
    logic       payload_esc;
    logic [7:0] sum;
    logic       sum_esc;
  } cmd_t;

endpackage

// ===== rtl/core/efe_front.sv =====
module efe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     payload_byte_i,
  input  logic           first_of_frame_i,
  input  logic           last_of_frame_i,
  input  logic           frame_kind_i,
  input  logic           q_full_i,
  output logic           push_o,
  output efe_pkg::cmd_t  cmd_o
);
  import efe_pkg::*;

  logic [7:0] sum_q;
  logic [7:0] sum_d;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Restart the sum on the first byte of a frame.
  assign sum_d = (first_of_frame_i ? 8'h00 : sum_q) + payload_byte_i;

  always_comb begin
    cmd_o.payload     = payload_byte_i;
    cmd_o.first       = first_of_frame_i;
    cmd_o.last        = last_of_frame_i;
    cmd_o.debug_kind  = frame_kind_i;
    cmd_o.payload_esc = (payload_byte_i == EscByte);
    cmd_o.sum         = sum_d;
    cmd_o.sum_esc     = (sum_d == EscByte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 8'h00;
    end else if (push_o) begin
      sum_q <= sum_d;
    end
  end

endmodule

// ===== rtl/core/efe_queue.sv =====
module efe_queue #(
  parameter int unsigned Depth = efe_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  efe_pkg::cmd_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output efe_pkg::cmd_t  head_o,
  output logic           empty_o
);
  import efe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/efe_back.sv =====
module efe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  efe_pkg::cmd_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o
);
  import efe_pkg::*;

  typedef enum logic [2:0] {
    StStart,
    StSofEsc,
    StSofCode,
    StPay,
    StPayCode,
    StEofEsc,
    StEofCode,
    StSum
  } step_e;

  step_e      step_q;
  step_e      cur_step;
  step_e      next_step;
  logic       advance;
  logic       done;
  logic [7:0] byte_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q;

  assign advance = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && done;

  always_comb begin
    cur_step  = step_q;
    next_step = StStart;
    done      = 1'b0;
    byte_d    = head_i.payload;
    if (step_q == StStart) begin
      cur_step = head_i.first ? StSofEsc : StPay;
    end
    case (cur_step)
      StSofEsc: begin
        byte_d    = EscByte;
        next_step = StSofCode;
      end
      StSofCode: begin
        byte_d    = head_i.debug_kind ? CodeDebug : CodeData;
        next_step = StPay;
      end
      StPay: begin
        // An escape byte on the wire equals the payload itself.
        byte_d = head_i.payload;
        if (head_i.payload_esc) begin
          next_step = StPayCode;
        end else if (head_i.last) begin
          next_step = StEofEsc;
        end else begin
          done = 1'b1;
        end
      end
      StPayCode: begin
        byte_d = CodeEsc;
        if (head_i.last) begin
          next_step = StEofEsc;
        end else begin
          done = 1'b1;
        end
      end
      StEofEsc: begin
        byte_d    = EscByte;
        next_step = StEofCode;
      end
      StEofCode: begin
        // Drop the sum byte when it would look like an escape.
        if (head_i.sum_esc) begin
          byte_d = CodeEofNc;
          done   = 1'b1;
        end else begin
          byte_d    = CodeEof;
          next_step = StSum;
        end
      end
      StSum: begin
        byte_d = head_i.sum;
        done   = 1'b1;
      end
      default: begin
        byte_d = head_i.payload;
        done   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StStart;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'h00;
      run_last_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      out_byte_q  <= byte_d;
      run_last_q  <= done;
      step_q      <= done ? StStart : next_step;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule

// ===== rtl/core/escaped_frame_encoder_with_sum.sv =====
// Escaped frame encoder with an 8-bit additive checksum.
//
// Input channel: one payload byte per transaction with first/last flags
// and a frame kind. Output channel: one line byte per transaction, with
// run_last_o marking the final byte caused by an input transaction.
// Both channels use valid/stall; a transaction completes when valid is
// high and stall is low.
//
// The front keeps the running sum and classifies each byte into a queue
// entry (QueueDepth deep). The back expands an entry into 1 to 7 line
// bytes, one per cycle unless the receiver stalls, from a registered
// output stage. The first line byte of an item goes through the queue
// entry and then the output register. The back gives an unescaped
// mid-frame byte as one line byte, an escaped one as two; a start
// marker adds two and an end marker two or three.
// Reset clears the sum, the queue and the output stage. While the
// receiver stalls, the output byte holds; the queue keeps taking input
// until it is full, then in_stall_o rises.
module escaped_frame_encoder_with_sum #(
  parameter int unsigned QueueDepth = efe_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  input  logic       first_of_frame_i,
  input  logic       last_of_frame_i,
  input  logic       frame_kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import efe_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  efe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .first_of_frame_i (first_of_frame_i),
    .last_of_frame_i  (last_of_frame_i),
    .frame_kind_i     (frame_kind_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  efe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty)
  );

  efe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

  a_queue_not_full_and_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(q_full && q_empty)
  ) else $error("queue reports full and empty at once");

  a_no_pop_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_empty |-> !pop
  ) else $error("back popped an empty queue");

  a_pop_gives_last_byte: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |=> (out_valid_o && run_last_o)
  ) else $error("retired entry did not present its final byte");

  a_push_only_when_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (q_full && !pop) |=> !q_empty
  ) else $error("full queue drained without a pop");

endmodule

// ===== test/escaped_frame_encoder_with_sum_tb.sv =====
module escaped_frame_encoder_with_sum_tb;
  import efe_pkg::*;

  localparam int unsigned RandomItems = 355;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
  } line_byte_t;

  typedef enum int unsigned {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [7:0] payload_byte_i   = 8'h00;
  logic       first_of_frame_i = 1'b0;
  logic       last_of_frame_i  = 1'b0;
  logic       frame_kind_i     = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  // Line bytes still owed by the encoder, oldest first.
  line_byte_t  line_bytes_q[$];
  line_byte_t  want_byte;
  logic [7:0]  frame_sum     = 8'h00;

  int unsigned mismatch_count = 0;
  int unsigned bytes_checked  = 0;
  int unsigned items_sent     = 0;
  int unsigned frames_sent    = 0;
  int unsigned escapes_sent   = 0;
  int unsigned nc_ends        = 0;
  int unsigned cycle_count    = 0;

  bit          gaps_on        = 1'b1;
  int          burst_left     = 4;
  stall_mode_e stall_mode     = StallNone;
  int unsigned stall_hold     = 0;

  escaped_frame_encoder_with_sum i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .first_of_frame_i (first_of_frame_i),
    .last_of_frame_i  (last_of_frame_i),
    .frame_kind_i     (frame_kind_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void report_mismatch(string msg);
    if (mismatch_count < MaxReports) begin
      $display("mismatch: %s", msg);
    end
    mismatch_count++;
  endfunction

  // Expand one payload byte into the line bytes it must produce.
  task automatic encode_item(logic [7:0] pb, logic first, logic last, logic kind);
    line_byte_t run_q[$];
    if (first) begin
      frame_sum = 8'h00;
      run_q.push_back('{EscByte, 1'b0});
      run_q.push_back('{(kind ? CodeDebug : CodeData), 1'b0});
    end
    frame_sum = frame_sum + pb;
    if (pb == EscByte) begin
      run_q.push_back('{EscByte, 1'b0});
      run_q.push_back('{CodeEsc, 1'b0});
      escapes_sent++;
    end else begin
      run_q.push_back('{pb, 1'b0});
    end
    if (last) begin
      if (frame_sum == EscByte) begin
        run_q.push_back('{EscByte, 1'b0});
        run_q.push_back('{CodeEofNc, 1'b0});
        nc_ends++;
      end else begin
        run_q.push_back('{EscByte, 1'b0});
        run_q.push_back('{CodeEof, 1'b0});
        run_q.push_back('{frame_sum, 1'b0});
      end
    end
    run_q[run_q.size() - 1].run_last = 1'b1;
    foreach (run_q[i]) line_bytes_q.push_back(run_q[i]);
  endtask

  task automatic send_byte(logic [7:0] pb, logic first, logic last, logic kind);
    in_valid_i       <= 1'b1;
    payload_byte_i   <= pb;
    first_of_frame_i <= first;
    last_of_frame_i  <= last;
    frame_kind_i     <= kind;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_item(pb, first, last, kind);
    items_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  function automatic logic [7:0] random_payload();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return EscByte;
    if (pick < 25) return 8'h00;
    if (pick < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_outside_frame();
    // No first flag since reset: bytes pass through, the last one closes.
    send_byte(8'h11, 1'b0, 1'b0, 1'b1);
    send_byte(EscByte, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_single_byte_frames();
    send_byte(8'h00, 1'b1, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    send_byte(EscByte, 1'b1, 1'b1, 1'b0);
    send_byte(EscByte, 1'b1, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b1, 1'b1, 1'b1);
    frames_sent += 5;
  endtask

  task automatic test_escapes_and_checksum();
    // Sum lands on the escape value: short end marker.
    send_byte(8'h2A, 1'b1, 1'b0, 1'b0);
    send_byte(8'h30, 1'b0, 1'b1, 1'b1);
    // Escape in mid frame.
    send_byte(8'h01, 1'b1, 1'b0, 1'b1);
    send_byte(EscByte, 1'b0, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1, 1'b1);
    // Sum wraps.
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b1, 1'b0);
    // Restart without an end, then bytes after the end keep the old sum.
    send_byte(8'h10, 1'b1, 1'b0, 1'b0);
    send_byte(8'h20, 1'b1, 1'b0, 1'b1);
    send_byte(8'h33, 1'b0, 1'b1, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1, 1'b1);
    frames_sent += 5;
  endtask

  task automatic test_random_frames();
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  pb;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      gaps_on = ((items_sent / 64) % 3) != 0;
      pick    = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          pb = random_payload();
          // Steer some frames so the checksum equals the escape value.
          if (i == len - 1 && i != 0 && $urandom_range(0, 3) == 0) pb = EscByte - frame_sum;
          send_byte(pb, i == 0, i == len - 1, 1'($urandom_range(0, 1)));
        end
        frames_sent++;
      end else if (pick < 90) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_byte(random_payload(), 1'b0, $urandom_range(0, 4) == 0,
                    1'($urandom_range(0, 1)));
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_byte(random_payload(), i == 0, 1'b0, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_outside_frame();
    test_single_byte_frames();
    test_escapes_and_checksum();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (line_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d payload bytes in about %0d frames, %0d escaped, %0d short end markers;",
             items_sent, frames_sent, escapes_sent, nc_ends);
    $display("checked %0d line bytes with %0d mismatches.", bytes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver stall pattern: switch to a randomly chosen mode whenever the hold count runs out.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_hold = $urandom_range(40, 200);
      end
      stall_hold--;
      case (stall_mode)
        StallNone:     out_stall_i <= 1'b0;
        StallRandom:   out_stall_i <= ($urandom_range(0, 2) == 0);
        StallPeriodic: out_stall_i <= ((stall_hold % 4) == 0);
        default:       out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each line byte transaction with the oldest owed byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (line_bytes_q.size() == 0) begin
        report_mismatch($sformatf("line byte %h with nothing pending", out_byte_o));
      end else begin
        want_byte = line_bytes_q.pop_front();
        if (out_byte_o !== want_byte.value) begin
          report_mismatch($sformatf("out_byte at line byte %0d: expected %h, got %h",
                                    bytes_checked, want_byte.value, out_byte_o));
        end
        if (run_last_o !== want_byte.run_last) begin
          report_mismatch($sformatf("run_last at line byte %0d: expected %b, got %b",
                                    bytes_checked, want_byte.run_last, run_last_o));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d line bytes pending",
             cycle_count, line_bytes_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
